// ----- hdl/olst_pkg.sv -----
package olst_pkg;

    localparam int PRELOAD_COUNT = 10;
    localparam logic [7:0] PRELOAD_FIRST = 8'h61;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_FIND   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    // Broadcast to every cell for one cycle when an insert or delete commits.
    typedef struct packed {
        logic       ins;
        logic       del;
        logic [6:0] pos;
        logic [7:0] val;
    } cmd_t;

    // Travels one cell per cycle along the row for a read or a find.
    typedef struct packed {
        logic       valid;
        logic       find;
        logic       hit;
        logic [6:0] pos;
        logic [7:0] data;
        logic [6:0] fpos;
    } probe_t;

endpackage

// ----- hdl/olst_cell.sv -----
module olst_cell #(
    parameter int CNT_W = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CNT_W-1:0]    cell_index,
    input  logic [CNT_W-1:0]    count,
    input  olst_pkg::cmd_t      cmd,
    input  logic [7:0]          left_entry,
    input  logic [7:0]          right_entry,
    output logic [7:0]          entry,
    input  olst_pkg::probe_t    probe_in,
    output olst_pkg::probe_t    probe_out
);

    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    logic [7:0]       entry_reg;
    logic [7:0]       entry_next;
    olst_pkg::probe_t probe_reg;
    olst_pkg::probe_t probe_next;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] idx_plus;
    logic [CMP_W-1:0] pos_ext;

    assign idx_ext  = CMP_W'(cell_index);
    assign idx_plus = idx_ext + CMP_W'(1);
    assign pos_ext  = CMP_W'(cmd.pos);

    // Insert moves the tail one place right; delete closes the gap from the right.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (idx_ext > pos_ext) begin
                entry_next = left_entry;
            end else if (idx_ext == pos_ext) begin
                entry_next = cmd.val;
            end
        end else if (cmd.del) begin
            if (idx_plus >= pos_ext) begin
                entry_next = right_entry;
            end
        end
    end

    always_comb begin
        probe_next = probe_in;
        if (probe_in.valid && !probe_in.hit) begin
            if (probe_in.find) begin
                if ((cell_index < count) && (entry_reg == probe_in.data)) begin
                    probe_next.hit  = 1'b1;
                    probe_next.fpos = 7'(idx_plus);
                end
            end else if (idx_plus == CMP_W'(probe_in.pos)) begin
                probe_next.hit  = 1'b1;
                probe_next.data = entry_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            if (cell_index < CNT_W'(olst_pkg::PRELOAD_COUNT)) begin
                entry_reg <= olst_pkg::PRELOAD_FIRST + 8'(cell_index);
            end else begin
                entry_reg <= 8'd0;
            end
            probe_reg <= '0;
        end else begin
            entry_reg <= entry_next;
            probe_reg <= probe_next;
        end
    end

    assign entry     = entry_reg;
    assign probe_out = probe_reg;

endmodule

// ----- hdl/olst_ctrl.sv -----
module olst_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output olst_pkg::cmd_t      cmd,
    output olst_pkg::probe_t    probe_launch,
    input  olst_pkg::probe_t    probe_ret,
    output logic [CNT_W-1:0]    count
);

    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    olst_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    olst_pkg::status_t status_reg, status_next;
    logic [7:0]        rdata_reg, rdata_next;
    logic [6:0]        fpos_reg, fpos_next;
    logic [6:0]        length_reg, length_next;

    olst_pkg::func_t   func;
    logic [6:0]        pos;
    logic [7:0]        val;
    logic              accept;
    logic              pos_beyond;
    logic              pos_zero;
    logic              list_full;

    assign func       = olst_pkg::func_t'(s_tuser);
    assign pos        = s_tdata[6:0];
    assign val        = s_tdata[14:7];
    assign s_tready   = (state_reg == olst_pkg::S_IDLE) && (!m_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign pos_beyond = CMP_W'(pos) > CMP_W'(count_reg);
    assign pos_zero   = (pos == 7'd0);
    assign list_full  = (count_reg >= CNT_W'(CAPACITY));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        rdata_next   = rdata_reg;
        fpos_next    = fpos_reg;
        length_next  = length_reg;
        cmd          = '0;
        probe_launch = '0;

        unique case (state_reg)
            olst_pkg::S_IDLE: begin
                if (accept) begin
                    status_next = olst_pkg::STAT_OK;
                    rdata_next  = 8'd0;
                    fpos_next   = 7'd0;
                    unique case (func)
                        olst_pkg::FUNC_INSERT: begin
                            m_valid_next = 1'b1;
                            if (pos_beyond) begin
                                status_next = olst_pkg::STAT_RANGE;
                            end else if (list_full) begin
                                status_next = olst_pkg::STAT_FULL;
                            end else begin
                                cmd.ins    = 1'b1;
                                cmd.pos    = pos;
                                cmd.val    = val;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        olst_pkg::FUNC_DELETE: begin
                            m_valid_next = 1'b1;
                            if (pos_zero || pos_beyond) begin
                                status_next = olst_pkg::STAT_RANGE;
                            end else begin
                                cmd.del    = 1'b1;
                                cmd.pos    = pos;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        olst_pkg::FUNC_READ: begin
                            if (pos_zero || pos_beyond) begin
                                m_valid_next = 1'b1;
                                status_next  = olst_pkg::STAT_RANGE;
                            end else begin
                                probe_launch.valid = 1'b1;
                                probe_launch.pos   = pos;
                                state_next         = olst_pkg::S_SCAN;
                            end
                        end
                        olst_pkg::FUNC_FIND: begin
                            probe_launch.valid = 1'b1;
                            probe_launch.find  = 1'b1;
                            probe_launch.data  = val;
                            state_next         = olst_pkg::S_SCAN;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                    length_next = 7'(count_next);
                end
            end
            olst_pkg::S_SCAN: begin
                // The probe left the last cell; the result register is empty by now.
                if (probe_ret.valid) begin
                    state_next   = olst_pkg::S_IDLE;
                    m_valid_next = 1'b1;
                    length_next  = 7'(count_reg);
                    if (probe_ret.find) begin
                        status_next = probe_ret.hit ? olst_pkg::STAT_OK
                                                    : olst_pkg::STAT_NOTFOUND;
                        rdata_next  = 8'd0;
                        fpos_next   = probe_ret.hit ? probe_ret.fpos : 7'd0;
                    end else begin
                        status_next = olst_pkg::STAT_OK;
                        rdata_next  = probe_ret.data;
                        fpos_next   = 7'd0;
                    end
                end
            end
            default: begin
                state_next = olst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= olst_pkg::S_IDLE;
            count_reg   <= CNT_W'(olst_pkg::PRELOAD_COUNT);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
        fpos_reg   <= fpos_next;
        length_reg <= length_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {length_reg, fpos_reg, rdata_reg, status_reg};
    assign count    = count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length exceeds capacity");

    a_no_accept_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == olst_pkg::S_SCAN) |-> !s_tready)
        else $error("request taken while a probe is in flight");

    a_probe_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        probe_ret.valid |-> (state_reg == olst_pkg::S_SCAN))
        else $error("probe returned with no scan pending");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.del |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("delete did not shrink the list");
`endif

endmodule

// ----- hdl/ordered_list_engine.sv -----
// Ordered list of bytes held in a row of CAPACITY cells, preloaded after reset with 'a' to 'j'
// at positions 1 to 10. Each request names an operation in s_tuser: insert after a position
// (0 is the front), delete, read at a position, or find the first position holding a value.
// Inserts, deletes and out-of-range requests are done in the cycle the request is taken, with
// every cell shifting in parallel, and the result is registered on the next clock.
// Reads and finds send a probe down the row one cell per clock; the result is registered when
// the probe leaves the last cell, so the length of the cell row sets how long it takes. One
// request is in flight at a time, and a new one is taken as soon as the result register is
// empty or being emptied in the same cycle. Every result carries the list length afterwards.
module ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // position[6:0], value[14:7], zero[15]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], read_data[9:2], found_position[16:10],
                                   // list_length[23:17]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    olst_pkg::cmd_t   cmd;
    olst_pkg::probe_t probe_chain [CAPACITY+1];
    logic [7:0]       entries [CAPACITY];
    logic [CNT_W-1:0] count;

    olst_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cmd          (cmd),
        .probe_launch (probe_chain[0]),
        .probe_ret    (probe_chain[CAPACITY]),
        .count        (count)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [7:0] left_entry;
        logic [7:0] right_entry;

        if (i == 0) begin : g_first
            assign left_entry = 8'd0;
        end else begin : g_inner_left
            assign left_entry = entries[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = 8'd0;
        end else begin : g_inner_right
            assign right_entry = entries[i+1];
        end

        olst_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_index  (CNT_W'(i)),
            .count       (count),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .probe_in    (probe_chain[i]),
            .probe_out   (probe_chain[i+1])
        );
    end

endmodule
